FILE: hdl/ub64_pkg.sv
// Types, constants and character mapping functions for the URL-safe Base64 codec.
// No dependencies; imported by ub64_group and url_safe_base64_codec.
`default_nettype none

package ub64_pkg;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UZ    = 8'h5A;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LZ    = 8'h7A;
    localparam logic [7:0] CHAR_D0    = 8'h30;
    localparam logic [7:0] CHAR_D9    = 8'h39;

    localparam logic [6:0] VALUE_BAD  = 7'd64;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam int GROUP_BYTES = 4;

    typedef struct packed {
        logic [23:0]                  buffer;
        logic [1:0]                   count;
        logic [GROUP_BYTES-1:0][7:0]  bytes;
        logic [2:0]                   num;
        logic                         last;
        logic                         err;
    } group_result_t;

    function automatic logic [7:0] value_to_char(input logic [5:0] v);
        logic [7:0] ve;
        ve = {2'b00, v};
        if (v < 6'd26)
            return CHAR_UA + ve;
        else if (v < 6'd52)
            return CHAR_LA + ve - 8'd26;
        else if (v < 6'd62)
            return CHAR_D0 + ve - 8'd52;
        else if (v == 6'd62)
            return CHAR_PLUS;
        else
            return CHAR_MINUS;
    endfunction

    function automatic logic [6:0] char_to_value(input logic [7:0] ch);
        logic [7:0] t;
        t = 8'd0;
        if (ch >= CHAR_UA && ch <= CHAR_UZ)
        begin
            t = ch - CHAR_UA;
            return t[6:0];
        end
        else if (ch >= CHAR_LA && ch <= CHAR_LZ)
        begin
            t = ch - CHAR_LA + 8'd26;
            return t[6:0];
        end
        else if (ch >= CHAR_D0 && ch <= CHAR_D9)
        begin
            t = ch - CHAR_D0 + 8'd52;
            return t[6:0];
        end
        else if (ch == CHAR_PLUS)
            return 7'd62;
        else if (ch == CHAR_MINUS)
            return 7'd63;
        else
            return VALUE_BAD;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ub64_group.sv
// Group step logic: merges one element into the group and forms the result burst.
// Depends on ub64_pkg.
`default_nettype none

module ub64_group (
    input  wire logic                    mode,
    input  wire logic [7:0]              data,
    input  wire logic                    last,
    input  wire logic [23:0]             buffer,
    input  wire logic [1:0]              count,
    output ub64_pkg::group_result_t      result
);
    import ub64_pkg::*;

    logic [6:0]  v;
    logic [7:0]  b0, b1, b2;
    logic [23:0] buf_n;
    logic [1:0]  cnt_n;
    logic        done;
    logic [7:0]  v8;

    always_comb
    begin
        v    = char_to_value(data);
        v8   = {1'b0, v};
        b0   = buffer[23:16];
        b1   = buffer[15:8];
        b2   = buffer[7:0];
        cnt_n = count + 2'd1;
        done = 1'b0;
        if (mode == MODE_ENCODE)
        begin
            buf_n = {buffer[15:0], data};
            done  = (cnt_n == 2'd3);
        end
        else
        begin
            case (count)
                2'd0:
                begin
                    b0 = {v8[5:0], 2'b00};
                    b1 = 8'd0;
                    b2 = 8'd0;
                end
                2'd1:
                begin
                    b0 = b0 | {4'd0, v8[7:4]};
                    b1 = {v8[3:0], 4'd0};
                end
                2'd2:
                begin
                    b1 = b1 | {2'd0, v8[7:2]};
                    b2 = {v8[1:0], 6'd0};
                end
                default:
                begin
                    b2   = b2 | v8;
                    done = 1'b1;
                end
            endcase
            buf_n = {b0, b1, b2};
        end

        result.bytes = '0;
        result.last  = last;
        result.err   = 1'b0;
        if (done)
        begin
            result.buffer = '0;
            result.count  = 2'd0;
            if (mode == MODE_ENCODE)
            begin
                result.bytes[0] = value_to_char(buf_n[23:18]);
                result.bytes[1] = value_to_char(buf_n[17:12]);
                result.bytes[2] = value_to_char(buf_n[11:6]);
                result.bytes[3] = value_to_char(buf_n[5:0]);
                result.num      = 3'd4;
            end
            else
            begin
                result.bytes[0] = buf_n[23:16];
                result.bytes[1] = buf_n[15:8];
                result.bytes[2] = buf_n[7:0];
                result.num      = 3'd3;
            end
        end
        else if (last)
        begin
            result.buffer = '0;
            result.count  = 2'd0;
            result.num    = 3'd1;
            result.err    = 1'b1;
        end
        else
        begin
            result.buffer = buf_n;
            result.count  = cnt_n;
            result.num    = 3'd0;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/url_safe_base64_codec.sv
// Top level of the URL-safe Base64 codec: request register, group state, result burst.
// Depends on ub64_pkg and ub64_group.
`default_nettype none

// Streaming URL-safe Base64 codec (alphabet A-Z a-z 0-9 + -, no padding). mode selects
// encode (0) or decode (1); writing it empties the current group. One request is taken
// into a request register, merged into the group from that register and, when the group
// completes, its four characters or three bytes are loaded into a burst register that
// drains one result per cycle while rsp_stall is low. Intake is one request per cycle
// while no burst is pending; while a burst drains the request register holds, and the
// next request advances in the cycle the final result of the burst is taken. A message
// that ends inside a group yields one result with length_error set, data_out 0 and
// last_out 1.
module url_safe_base64_codec (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        mode_wr_en,
    input  wire logic        mode_wr_data,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [7:0]  data_in,
    input  wire logic        last_in,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic [7:0]       data_out,
    output logic             last_out,
    output logic             length_error
);
    import ub64_pkg::*;

    logic                        mode_reg;
    logic                        req_valid_reg;
    logic [7:0]                  data_reg;
    logic                        last_reg;
    logic [23:0]                 buffer_reg;
    logic [1:0]                  count_reg;
    logic [GROUP_BYTES-1:0][7:0] burst_reg;
    logic [2:0]                  burst_cnt_reg;
    logic                        burst_last_reg;
    logic                        burst_err_reg;

    group_result_t               step;
    logic                        rsp_take;
    logic                        load_ok;
    logic                        advance;
    logic                        accept;

    ub64_group u_group (
        .mode   (mode_reg),
        .data   (data_reg),
        .last   (last_reg),
        .buffer (buffer_reg),
        .count  (count_reg),
        .result (step)
    );

    assign rsp_valid    = (burst_cnt_reg != 3'd0);
    assign rsp_take     = rsp_valid && !rsp_stall;
    assign load_ok      = (burst_cnt_reg == 3'd0) || ((burst_cnt_reg == 3'd1) && rsp_take);
    assign advance      = req_valid_reg && load_ok;
    assign req_stall    = req_valid_reg && !advance;
    assign accept       = req_valid && !req_stall;

    assign data_out     = burst_reg[0];
    assign last_out     = burst_last_reg && (burst_cnt_reg == 3'd1);
    assign length_error = burst_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_ENCODE;
            req_valid_reg <= 1'b0;
            buffer_reg    <= '0;
            count_reg     <= 2'd0;
            burst_cnt_reg <= 3'd0;
        end
        else
        begin
            if (accept)
                req_valid_reg <= 1'b1;
            else if (advance)
                req_valid_reg <= 1'b0;

            if (mode_wr_en)
            begin
                mode_reg   <= mode_wr_data;
                buffer_reg <= '0;
                count_reg  <= 2'd0;
            end
            else if (advance)
            begin
                buffer_reg <= step.buffer;
                count_reg  <= step.count;
            end

            if (advance)
                burst_cnt_reg <= step.num;
            else if (rsp_take)
                burst_cnt_reg <= burst_cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_in;
            last_reg <= last_in;
        end
        if (advance)
        begin
            burst_reg      <= step.bytes;
            burst_last_reg <= step.last;
            burst_err_reg  <= step.err;
        end
        else if (rsp_take)
        begin
            burst_reg <= {8'd0, burst_reg[GROUP_BYTES-1:1]};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        burst_cnt_reg <= 3'd4)
        else $error("result burst count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && length_error |-> last_out && (data_out == 8'd0))
        else $error("length error result not final or not zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && !advance |=> req_valid_reg && $stable(data_reg) && $stable(last_reg))
        else $error("held request lost");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (step.num != 3'd0) |=> rsp_valid)
        else $error("loaded burst not presented");

endmodule

`default_nettype wire
